/* hdl/musb_pkg.sv */
`default_nettype none

package musb_pkg;

  localparam int USERS_DEF     = 4;
  localparam int ROW_WIDTH_DEF = 80;
  localparam int ROWS_DEF      = 32;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_END   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PAD,
    ST_RDATA
  } state_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic       cell_valid;
    logic [4:0] row_count;
  } res_t;

endpackage

`default_nettype wire

/* hdl/musb_text_mem.sv */
`default_nettype none

module musb_text_mem #(
  parameter int USERS     = musb_pkg::USERS_DEF,
  parameter int ROW_WIDTH = musb_pkg::ROW_WIDTH_DEF,
  parameter int ROWS      = musb_pkg::ROWS_DEF,
  localparam int UW = (USERS > 1) ? $clog2(USERS) : 1,
  localparam int RW = $clog2(ROWS),
  localparam int CW = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1
) (
  input  wire logic               clk,
  input  wire musb_pkg::mem_ctl_t ctl,
  input  wire logic [UW-1:0]      user,
  input  wire logic [RW-1:0]      row,
  input  wire logic [CW-1:0]      col,
  input  wire logic [7:0]         wdata,
  output logic [7:0]              rdata
);
  import musb_pkg::*;

  localparam int DEPTH = USERS * ROWS * ROW_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] addr;

  // flat cell index: user, then row, then column
  assign addr = AW'((32'(user) * ROWS + 32'(row)) * ROW_WIDTH + 32'(col));

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/musb_seq.sv */
`default_nettype none

module musb_seq #(
  parameter int USERS     = musb_pkg::USERS_DEF,
  parameter int ROW_WIDTH = musb_pkg::ROW_WIDTH_DEF,
  parameter int ROWS      = musb_pkg::ROWS_DEF,
  localparam int UW = (USERS > 1) ? $clog2(USERS) : 1,
  localparam int RW = $clog2(ROWS),
  localparam int CW = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         command,
  input  wire logic [1:0]         user,
  input  wire logic [7:0]         character,
  input  wire logic [4:0]         line,
  input  wire logic [6:0]         column,
  input  wire logic               out_free,
  output logic                    res_load,
  output musb_pkg::res_t          res,
  output musb_pkg::mem_ctl_t      mem_ctl,
  output logic [UW-1:0]           mem_user,
  output logic [RW-1:0]           mem_row,
  output logic [CW-1:0]           mem_col,
  output logic [7:0]              mem_wdata,
  input  wire logic [7:0]         mem_rdata
);
  import musb_pkg::*;

  localparam logic [RW:0] ROWS_EXT  = (RW+1)'(ROWS);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW:0] WIDTH_EXT = (CW+1)'(ROW_WIDTH);

  state_t state, state_next;

  cmd_t       item_cmd;
  logic [1:0] item_user;
  logic [7:0] item_char;
  logic [4:0] item_line;
  logic [6:0] item_col;

  logic [RW-1:0] first_row    [USERS];
  logic [RW-1:0] visible_rows [USERS];
  logic [CW-1:0] write_column [USERS];

  logic [UW-1:0] ui;
  logic          known;
  logic [RW-1:0] fr, vr, fr_inc, put_vr;
  logic [CW-1:0] wc;
  logic [CW:0]   wc_inc;
  logic          col_full;
  logic [RW:0]   pend_sum, read_sum;
  logic [RW-1:0] pend_row, read_row;
  logic          read_ok;
  logic          is_put;

  logic          upd;
  logic [RW-1:0] fr_new, vr_new;
  logic [CW-1:0] wc_new;

  assign ui    = UW'(item_user);
  assign known = 32'(item_user) < USERS;
  assign fr    = first_row[ui];
  assign vr    = visible_rows[ui];
  assign wc    = write_column[ui];

  assign fr_inc   = (fr == ROW_LAST) ? '0 : fr + RW'(1);
  assign wc_inc   = {1'b0, wc} + (CW+1)'(1);
  assign col_full = (wc_inc == WIDTH_EXT);
  assign put_vr   = (col_full && vr != ROW_LAST) ? vr + RW'(1) : vr;

  assign pend_sum = {1'b0, fr} + {1'b0, vr};
  assign pend_row = (pend_sum >= ROWS_EXT) ? RW'(pend_sum - ROWS_EXT) : pend_sum[RW-1:0];
  assign read_sum = {1'b0, fr} + {1'b0, RW'(item_line)};
  assign read_row = (read_sum >= ROWS_EXT) ? RW'(read_sum - ROWS_EXT) : read_sum[RW-1:0];
  assign read_ok  = (32'(item_line) < 32'(vr)) && (32'(item_col) < ROW_WIDTH);

  // a real character (a nul byte ends the text instead)
  assign is_put = (item_cmd == CMD_WRITE) && (item_char != CHAR_NUL);

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_next = ST_IDLE;
          if (known) begin
            case (item_cmd)
              CMD_WRITE, CMD_END: begin
                if (!is_put && wc != '0) begin
                  state_next = ST_PAD;
                end
              end
              CMD_READ: begin
                if (read_ok) begin
                  state_next = ST_RDATA;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_PAD: begin
        if (out_free && col_full) begin
          state_next = ST_IDLE;
        end
      end
      ST_RDATA: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl   = '0;
    mem_user  = ui;
    mem_row   = pend_row;
    mem_col   = wc;
    mem_wdata = item_char;
    upd       = 1'b0;
    fr_new    = fr;
    vr_new    = vr;
    wc_new    = wc;
    res       = '0;
    res_load  = 1'b0;
    case (state)
      ST_EXEC: begin
        if (out_free) begin
          if (!known) begin
            res_load = 1'b1;
          end else begin
            case (item_cmd)
              CMD_WRITE, CMD_END: begin
                if (is_put) begin
                  mem_ctl.we    = 1'b1;
                  upd           = 1'b1;
                  wc_new        = col_full ? '0 : wc_inc[CW-1:0];
                  fr_new        = (col_full && vr == ROW_LAST) ? fr_inc : fr;
                  vr_new        = put_vr;
                  res_load      = 1'b1;
                  res.row_count = 5'(put_vr);
                end else if (wc == '0) begin
                  res_load      = 1'b1;
                  res.row_count = 5'(vr);
                end
              end
              CMD_READ: begin
                if (read_ok) begin
                  mem_ctl.re = 1'b1;
                  mem_row    = read_row;
                  mem_col    = CW'(item_col);
                end else begin
                  res_load      = 1'b1;
                  res.row_count = 5'(vr);
                end
              end
              CMD_CLEAR: begin
                upd      = 1'b1;
                fr_new   = '0;
                vr_new   = '0;
                wc_new   = '0;
                res_load = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
      ST_PAD: begin
        if (out_free) begin
          mem_ctl.we = 1'b1;
          mem_wdata  = CHAR_SPACE;
          upd        = 1'b1;
          wc_new     = col_full ? '0 : wc_inc[CW-1:0];
          fr_new     = (col_full && vr == ROW_LAST) ? fr_inc : fr;
          vr_new     = put_vr;
          if (col_full) begin
            res_load      = 1'b1;
            res.row_count = 5'(put_vr);
          end
        end
      end
      ST_RDATA: begin
        if (out_free) begin
          res_load       = 1'b1;
          res.cell_char  = mem_rdata;
          res.cell_valid = 1'b1;
          res.row_count  = 5'(vr);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      item_cmd  <= cmd_t'(command);
      item_user <= user;
      item_char <= character;
      item_line <= line;
      item_col  <= column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < USERS; i++) begin
        first_row[i]    <= '0;
        visible_rows[i] <= '0;
        write_column[i] <= '0;
      end
    end else if (upd) begin
      first_row[ui]    <= fr_new;
      visible_rows[ui] <= vr_new;
      write_column[ui] <= wc_new;
    end
  end

endmodule

`default_nettype wire

/* hdl/multi_user_scrollback_text_buffer_top.sv */
`default_nettype none

// Scrollback text buffer for USERS users, each with ROWS rows of ROW_WIDTH
// characters in one shared single-port character memory; at most ROWS-1
// committed rows stay visible per user, the oldest scrolling out first.
// Commands: write character (a nul byte ends the text), end of text (pads
// the partial row with spaces and commits it), read one cell of a visible
// line, clear user. Every request returns one result; row_count is the
// user's visible row count after the request, and requests for a user
// beyond USERS return all zeros. One request is in work at a time. A read
// of a visible cell waits on a registered memory read, and an end of text
// on a partly written row pads it one space per cycle through the memory
// write port, pausing while a result waits stalled in the output register.
// Results sit in an output register, so a new request is taken while a
// result waits.

module multi_user_scrollback_text_buffer_top #(
  parameter int USERS     = musb_pkg::USERS_DEF,
  parameter int ROW_WIDTH = musb_pkg::ROW_WIDTH_DEF,
  parameter int ROWS      = musb_pkg::ROWS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] command,
  input  wire logic [1:0] user,
  input  wire logic [7:0] character,
  input  wire logic [4:0] line,
  input  wire logic [6:0] column,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      cell_char,
  output logic            cell_valid,
  output logic [4:0]      row_count
);
  import musb_pkg::*;

  localparam int UW = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int RW = $clog2(ROWS);
  localparam int CW = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;

  logic          out_free;
  logic          res_load;
  res_t          res;
  mem_ctl_t      mem_ctl;
  logic [UW-1:0] mem_user;
  logic [RW-1:0] mem_row;
  logic [CW-1:0] mem_col;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  assign out_free = !out_valid || !out_stall;

  musb_seq #(
    .USERS     (USERS),
    .ROW_WIDTH (ROW_WIDTH),
    .ROWS      (ROWS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .user      (user),
    .character (character),
    .line      (line),
    .column    (column),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .mem_ctl   (mem_ctl),
    .mem_user  (mem_user),
    .mem_row   (mem_row),
    .mem_col   (mem_col),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  musb_text_mem #(
    .USERS     (USERS),
    .ROW_WIDTH (ROW_WIDTH),
    .ROWS      (ROWS)
  ) u_text_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .user  (mem_user),
    .row   (mem_row),
    .col   (mem_col),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      cell_char  <= res.cell_char;
      cell_valid <= res.cell_valid;
      row_count  <= res.row_count;
    end
  end

endmodule

`default_nettype wire

/* tb/scrollback_checker.sv */
`timescale 1ns / 100ps

module scrollback_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] command,
  input  logic [1:0] user,
  input  logic [7:0] character,
  input  logic [4:0] line,
  input  logic [6:0] column,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] cell_char,
  input  logic       cell_valid,
  input  logic [4:0] row_count,
  output int         fail_count,
  output int         outstanding,
  output int         checked,
  output int         hits
);
  import musb_pkg::*;

  localparam int USERS     = USERS_DEF;
  localparam int ROW_WIDTH = ROW_WIDTH_DEF;
  localparam int ROWS      = ROWS_DEF;

  logic [7:0]  scroll_text [USERS][ROWS][ROW_WIDTH];
  int unsigned top_row     [USERS];
  int unsigned shown_rows  [USERS];
  int unsigned cursor_col  [USERS];

  res_t awaited_cells [$];
  int   err_tally   = 0;
  int   check_tally = 0;
  int   hit_tally   = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
    checked     = 0;
    hits        = 0;
  end

  task automatic commit_line(input int u);
    if (shown_rows[u] + 1 >= ROWS) begin
      top_row[u] = (top_row[u] + 1) % ROWS;
    end else begin
      shown_rows[u] = shown_rows[u] + 1;
    end
    cursor_col[u] = 0;
  endtask

  // pad the partial row with spaces and commit it
  task automatic close_line(input int u);
    int unsigned row;
    if (cursor_col[u] != 0) begin
      row = (top_row[u] + shown_rows[u]) % ROWS;
      for (int unsigned c = cursor_col[u]; c < ROW_WIDTH; c++) begin
        scroll_text[u][row][c] = CHAR_SPACE;
      end
      commit_line(u);
    end
  endtask

  task automatic advance_scrollback(input cmd_t op, input logic [1:0] who,
                                    input logic [7:0] ch, input logic [4:0] ln,
                                    input logic [6:0] col, output res_t r);
    int          u;
    int unsigned row;
    u = who;
    r = '0;
    if (u < USERS) begin
      case (op)
        CMD_WRITE: begin
          if (ch == CHAR_NUL) begin
            close_line(u);
          end else begin
            row = (top_row[u] + shown_rows[u]) % ROWS;
            if (cursor_col[u] >= ROW_WIDTH) cursor_col[u] = 0;
            scroll_text[u][row][cursor_col[u]] = ch;
            cursor_col[u] = cursor_col[u] + 1;
            if (cursor_col[u] >= ROW_WIDTH) commit_line(u);
          end
        end
        CMD_END: begin
          close_line(u);
        end
        CMD_READ: begin
          if (ln < shown_rows[u] && col < ROW_WIDTH) begin
            row = (top_row[u] + ln) % ROWS;
            r.cell_char  = scroll_text[u][row][col];
            r.cell_valid = 1'b1;
          end
        end
        default: begin
          top_row[u]    = 0;
          shown_rows[u] = 0;
          cursor_col[u] = 0;
        end
      endcase
      r.row_count = shown_rows[u][4:0];
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      err_tally++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t fresh;
    if (rst) begin
      awaited_cells.delete();
      for (int u = 0; u < USERS; u++) begin
        top_row[u]    = 0;
        shown_rows[u] = 0;
        cursor_col[u] = 0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_cells.size() == 0) begin
          err_tally++;
          $error("result with no request waiting: cell_char %0d cell_valid %0d row_count %0d",
                 cell_char, cell_valid, row_count);
        end else begin
          want = awaited_cells.pop_front();
          check_field("cell_char", want.cell_char, cell_char);
          check_field("cell_valid", 8'(want.cell_valid), 8'(cell_valid));
          check_field("row_count", 8'(want.row_count), 8'(row_count));
          check_tally++;
          if (want.cell_valid) hit_tally++;
        end
      end
      if (in_valid && !in_stall) begin
        advance_scrollback(cmd_t'(command), user, character, line, column, fresh);
        awaited_cells.push_back(fresh);
      end
    end
    fail_count  <= err_tally;
    outstanding <= awaited_cells.size();
    checked     <= check_tally;
    hits        <= hit_tally;
  end

endmodule

/* tb/multi_user_scrollback_text_buffer_top_test.sv */
`timescale 1ns / 100ps

module multi_user_scrollback_text_buffer_top_test;
  import musb_pkg::*;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [1:0] command   = CMD_WRITE;
  logic [1:0] user      = '0;
  logic [7:0] character = '0;
  logic [4:0] line      = '0;
  logic [6:0] column    = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] cell_char;
  logic       cell_valid;
  logic [4:0] row_count;

  int   fail_count;
  int   outstanding;
  int   checked;
  int   hits;
  int   tx_idle = 15;
  int   rx_idle = 45;
  int   n_sent  = 0;
  int   sent_by_cmd [4] = '{0, 0, 0, 0};
  logic long_hold = 1'b0;
  event hold_go;

  initial begin
    forever #6 clk = ~clk;
  end

  multi_user_scrollback_text_buffer_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .user       (user),
    .character  (character),
    .line       (line),
    .column     (column),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_char  (cell_char),
    .cell_valid (cell_valid),
    .row_count  (row_count)
  );

  scrollback_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .user        (user),
    .character   (character),
    .line        (line),
    .column      (column),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cell_char   (cell_char),
    .cell_valid  (cell_valid),
    .row_count   (row_count),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked),
    .hits        (hits)
  );

  // long receiver hold-off so the block backs up into its input
  initial begin : hold_off
    @(hold_go);
    long_hold <= 1'b1;
    repeat (300) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !rst && (long_hold || ($urandom_range(99) < rx_idle));
  end

  task automatic send_request(input cmd_t op, input logic [1:0] who, input logic [7:0] ch,
                              input logic [4:0] ln, input logic [6:0] col);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= op;
    user      <= who;
    character <= ch;
    line      <= ln;
    column    <= col;
    do @(posedge clk); while (in_stall);
    n_sent++;
    sent_by_cmd[op]++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int pick;
    int u;
    int len;
    int phase_start;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store, end of text at column zero
    send_request(CMD_READ, 2'd0, 8'h00, 5'd0, 7'd0);
    send_request(CMD_END, 2'd0, 8'hff, 5'd31, 7'd127);
    // partial row padded by end of text
    send_request(CMD_WRITE, 2'd0, 8'hff, 5'd0, 7'd0);
    send_request(CMD_WRITE, 2'd0, 8'h01, 5'd0, 7'd0);
    send_request(CMD_WRITE, 2'd0, CHAR_SPACE, 5'd0, 7'd0);
    send_request(CMD_END, 2'd0, 8'h00, 5'd0, 7'd0);
    send_request(CMD_READ, 2'd0, 8'h00, 5'd0, 7'd0);
    send_request(CMD_READ, 2'd0, 8'h00, 5'd0, 7'd2);
    send_request(CMD_READ, 2'd0, 8'h00, 5'd0, 7'd79);
    // reads past the row width and past the visible lines
    send_request(CMD_READ, 2'd0, 8'h00, 5'd0, 7'd80);
    send_request(CMD_READ, 2'd0, 8'h00, 5'd0, 7'd127);
    send_request(CMD_READ, 2'd0, 8'h00, 5'd1, 7'd0);
    send_request(CMD_READ, 2'd0, 8'h00, 5'd31, 7'd0);
    // nul byte terminates the text
    send_request(CMD_WRITE, 2'd1, 8'haa, 5'd0, 7'd0);
    send_request(CMD_WRITE, 2'd1, CHAR_NUL, 5'd0, 7'd0);
    send_request(CMD_READ, 2'd1, 8'h00, 5'd0, 7'd0);
    send_request(CMD_READ, 2'd1, 8'h00, 5'd0, 7'd1);
    send_request(CMD_END, 2'd1, 8'h00, 5'd0, 7'd0);
    // clear drops a partial row and the view
    send_request(CMD_WRITE, 2'd2, 8'h55, 5'd0, 7'd0);
    send_request(CMD_CLEAR, 2'd2, 8'h00, 5'd0, 7'd0);
    send_request(CMD_READ, 2'd2, 8'h00, 5'd0, 7'd0);
    send_request(CMD_END, 2'd2, 8'h00, 5'd0, 7'd0);
    send_request(CMD_CLEAR, 2'd0, 8'h00, 5'd0, 7'd0);
    send_request(CMD_READ, 2'd0, 8'h00, 5'd0, 7'd0);
    send_request(CMD_WRITE, 2'd3, 8'h7f, 5'd0, 7'd0);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle = (phase == 0) ? 15 : (phase == 1) ? 45 : 0;
      rx_idle <= (phase == 0) ? 45 : (phase == 1) ? 15 : 0;
      if (phase == 2) -> hold_go;
      phase_start = n_sent;
      while (n_sent - phase_start < 334) begin
        pick = $urandom_range(99);
        u = ($urandom_range(99) < 60) ? 0 : $urandom_range(3);
        if (pick < 65) begin
          // one line of text, mostly short, sometimes a full or nearly full row
          pick = $urandom_range(99);
          len = (pick < 3) ? ROW_WIDTH_DEF :
                (pick < 6) ? ROW_WIDTH_DEF - 1 - $urandom_range(4) : 1 + $urandom_range(4);
          repeat (len) begin
            send_request(CMD_WRITE, 2'(u), 8'($urandom_range(255, 1)), 5'($urandom),
                         7'($urandom));
          end
          pick = $urandom_range(9);
          if (pick < 7) begin
            send_request(CMD_END, 2'(u), 8'($urandom), 5'($urandom), 7'($urandom));
          end else if (pick < 9) begin
            send_request(CMD_WRITE, 2'(u), CHAR_NUL, 5'($urandom), 7'($urandom));
          end
        end else if (pick < 90) begin
          repeat ($urandom_range(4, 1)) begin
            send_request(CMD_READ, 2'(u), 8'($urandom),
                         ($urandom_range(1) != 0) ? 5'($urandom) : 5'($urandom_range(3)),
                         ($urandom_range(99) < 85) ? 7'($urandom_range(79)) : 7'($urandom));
          end
        end else if (pick < 95) begin
          send_request(CMD_END, 2'(u), 8'($urandom), 5'($urandom), 7'($urandom));
        end else if (pick < 96) begin
          send_request(CMD_CLEAR, 2'(u), 8'($urandom), 5'($urandom), 7'($urandom));
        end else begin
          send_request(cmd_t'($urandom_range(3)), 2'($urandom), 8'($urandom), 5'($urandom),
                       7'($urandom));
        end
      end
      wait_drained();
    end

    repeat (100) @(posedge clk);
    $display("covered %0d requests: %0d writes, %0d end-of-text, %0d reads, %0d clears",
             n_sent, sent_by_cmd[CMD_WRITE], sent_by_cmd[CMD_END], sent_by_cmd[CMD_READ],
             sent_by_cmd[CMD_CLEAR]);
    $display("%0d results checked, %0d reads hit visible cells", checked, hits);
    if (fail_count == 0 && outstanding == 0) begin
      $display("multi_user_scrollback_text_buffer_top: match");
    end else begin
      $display("multi_user_scrollback_text_buffer_top: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("multi_user_scrollback_text_buffer_top: mismatch");
    $finish;
  end

endmodule
